[rtl/tdc_fine_time_calibrator_core_defines.svh]
// ----------------------------------------------------------------------------
// TDC fine time calibrator: assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TDC_FINE_TIME_CALIBRATOR_CORE_DEFINES_SVH
`define TDC_FINE_TIME_CALIBRATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/tfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC fine time calibrator package
// Codes, widths and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package tfc_pkg;

   localparam int CNT_W  = 32;
   localparam int PS_W   = 16;
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_LAST = 4'd15;

   localparam logic [PS_W-1:0] PERIOD_RESET = 16'd5000;

   localparam logic CSR_MIN_STAT = 1'b0;
   localparam logic CSR_PERIOD   = 1'b1;

   typedef enum logic [1:0] {
      FUNC_HIT  = 2'd0,
      FUNC_CAL  = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FEW   = 2'd2,
      ST_UNCAL = 2'd3
   } status_type;

   typedef struct packed {
      logic clr_step;
      logic load_item;
      logic rd_loop;
      logic exec;
      logic bin_clr;
      logic sum_acc;
      logic part_acc;
      logic mul_step;
      logic div_init;
      logic div_step;
      logic cal_write;
      logic res_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic cal_go;
      logic bin_last;
      logic step_last;
      logic total_zero;
      logic res_free;
   } stat_type;

endpackage

[rtl/tdc_fine_time_calibrator_core.sv]
`timescale 1ns / 1ps
`include "tdc_fine_time_calibrator_core_defines.svh"
// ----------------------------------------------------------------------------
// TDC fine time calibrator core
// Code-density calibration of TDC fine times per detector channel.
// ----------------------------------------------------------------------------
// Items enter on the req_ channel (valid/stall) and each gives one result on
// the rsp_ channel (valid/stall). A hit item updates the channel's histogram
// bin and hit count; a read item returns a stored table value; a calibrate
// item rebuilds the channel's table from its histogram.
// Hit and read items address the memories when accepted and update them in
// the execute state, with the result registered in the next accept cycle.
// Each memory has a single read port.
// A calibrate item makes a summing pass over the fine bins, then walks them:
// a 16-step shift-add multiplier and a 16-step restoring divider are shared
// across all bins.
// After reset the histogram and hit count memories are cleared, one entry a
// cycle over channels times fine bins entries (65536 at the default size);
// req_stall is high throughout. Configuration writes on the csr_ port are
// always taken. A stalled result stays in the output register; a new item
// can be taken from idle, but its result loads only once the register frees.
// ----------------------------------------------------------------------------
module tdc_fine_time_calibrator_core import tfc_pkg::*; #(
   parameter int NUM_PLANES   = 2,
   parameter int NUM_SECTIONS = 2,
   parameter int NUM_ANODES   = 16,
   parameter int FINE_BINS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_plane,
   input  logic [1:0]  req_section,
   input  logic [4:0]  req_anode,
   input  logic [9:0]  req_fine_bin,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_calib_ps,
   output logic [31:0] rsp_hit_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);

   cmd_type  cmd;
   stat_type st;

   assign csr_ready = 1'b1;

   tfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   tfc_datapath #(
      .NUM_PLANES   (NUM_PLANES),
      .NUM_SECTIONS (NUM_SECTIONS),
      .NUM_ANODES   (NUM_ANODES),
      .FINE_BINS    (FINE_BINS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .st            (st),
      .req_func      (req_func),
      .req_plane     (req_plane),
      .req_section   (req_section),
      .req_anode     (req_anode),
      .req_fine_bin  (req_fine_bin),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_stall     (rsp_stall),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_calib_ps  (rsp_calib_ps),
      .rsp_hit_total (rsp_hit_total)
   );

   `TFC_ASSERT_NEXT(a_one_item, clock, reset, req_valid && !req_stall, req_stall, "second item taken before the first finished")
   `TFC_ASSERT_SAME(a_calib_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_calib_ps == 16'd0, "table value on a failed item")
   `TFC_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, !rsp_valid && req_stall, "block not quiet after reset")

endmodule

[rtl/tfc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tfc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tfc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC fine time calibrator datapath
// Histogram, hit count and table memories, configuration registers, the
// shift-add multiplier, the restoring divider and the result register.
// ----------------------------------------------------------------------------
module tfc_datapath import tfc_pkg::*; #(
   parameter int NUM_PLANES   = 2,
   parameter int NUM_SECTIONS = 2,
   parameter int NUM_ANODES   = 16,
   parameter int FINE_BINS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    st,
   input  logic [1:0]  req_func,
   input  logic [1:0]  req_plane,
   input  logic [1:0]  req_section,
   input  logic [4:0]  req_anode,
   input  logic [9:0]  req_fine_bin,
   input  logic        csr_valid,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_calib_ps,
   output logic [31:0] rsp_hit_total
);

   localparam int NCHAN  = NUM_PLANES * NUM_SECTIONS * NUM_ANODES;
   localparam int CH_W   = (NCHAN > 1) ? $clog2(NCHAN) : 1;
   localparam int BIN_W  = $clog2(FINE_BINS);
   localparam int DEPTH  = NCHAN * FINE_BINS;
   localparam int A_W    = $clog2(DEPTH);
   localparam int TOT_W  = CNT_W + BIN_W;
   localparam int PROD_W = TOT_W + PS_W;

   function automatic logic [A_W-1:0] mk_addr(input logic [CH_W-1:0] c,
                                               input logic [BIN_W-1:0] b);
      mk_addr = A_W'(c) * A_W'(FINE_BINS) + A_W'(b);
   endfunction

   // Configuration and control registers.
   logic [CNT_W-1:0] min_stat_ff;
   logic [PS_W-1:0]  period_ff;
   logic [A_W-1:0]   clr_addr_ff;
   logic [NCHAN-1:0] calib_flag_ff;
   logic             rsp_valid_ff;

   // Item and work registers.
   func_type         func_ff;
   logic             chan_ok_ff;
   logic             bin_ok_ff;
   logic [CH_W-1:0]  ch_ff;
   logic [A_W-1:0]   addr_ff;
   logic [BIN_W-1:0] b_ff;
   logic [STEP_W-1:0] k_ff;
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] part_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TOT_W-1:0] rem_ff;
   logic [PS_W-1:0]  lo_ff;
   logic [PS_W-1:0]  quot_ff;
   status_type       pend_status_ff;
   logic [PS_W-1:0]  pend_calib_ff;
   logic [CNT_W-1:0] pend_total_ff;
   status_type       rsp_status_ff;
   logic [PS_W-1:0]  rsp_calib_ff;
   logic [CNT_W-1:0] rsp_total_ff;

   // Decode of the offered item.
   logic             chan_ok_req;
   logic             bin_ok_req;
   logic [8:0]       ch_wide;
   logic [CH_W-1:0]  ch_req;
   logic [BIN_W-1:0] bin_req;

   // Memory ports.
   logic             hist_we;
   logic [A_W-1:0]   hist_waddr;
   logic [CNT_W-1:0] hist_wdata;
   logic [A_W-1:0]   hist_raddr;
   logic [CNT_W-1:0] hist_q;
   logic             cnt_we;
   logic [CH_W-1:0]  cnt_waddr;
   logic [CNT_W-1:0] cnt_wdata;
   logic [CNT_W-1:0] cnt_q;
   logic [CNT_W-1:0] cnt_new;
   logic [PS_W-1:0]  calib_q;

   // Divider step.
   logic [TOT_W:0]   div_t;
   logic [TOT_W:0]   div_diff;
   logic             div_ge;
   logic [TOT_W-1:0] rem_in;

   logic             res_free;

   always_comb begin
      chan_ok_req = (req_plane != 2'd0) && ({1'b0, req_plane} <= 3'(NUM_PLANES)) &&
                    (req_section != 2'd0) && ({1'b0, req_section} <= 3'(NUM_SECTIONS)) &&
                    (req_anode != 5'd0) && ({1'b0, req_anode} <= 6'(NUM_ANODES));
      ch_wide = ((9'(req_plane) - 9'd1) * 9'(NUM_SECTIONS) + 9'(req_section) - 9'd1)
                * 9'(NUM_ANODES) + 9'(req_anode) - 9'd1;
      ch_req     = ch_wide[CH_W-1:0];
      bin_ok_req = 13'(req_fine_bin) < 13'(FINE_BINS);
      bin_req    = BIN_W'(req_fine_bin);
   end

   assign cnt_new = (cnt_q != '1) ? cnt_q + 32'd1 : cnt_q;

   always_comb begin
      hist_raddr = cmd.rd_loop ? mk_addr(ch_ff, b_ff) : mk_addr(ch_req, bin_req);
      hist_we    = cmd.clr_step ||
                   (cmd.exec && (func_ff == FUNC_HIT) && chan_ok_ff && bin_ok_ff &&
                    (hist_q != '1));
      hist_waddr = cmd.clr_step ? clr_addr_ff : addr_ff;
      hist_wdata = cmd.clr_step ? '0 : hist_q + 32'd1;
      cnt_we     = (cmd.clr_step && (clr_addr_ff < A_W'(NCHAN))) ||
                   (cmd.exec && (func_ff == FUNC_HIT) && chan_ok_ff);
      cnt_waddr  = cmd.clr_step ? clr_addr_ff[CH_W-1:0] : ch_ff;
      cnt_wdata  = cmd.clr_step ? '0 : cnt_new;
   end

   tfc_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_hist (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (hist_waddr),
      .wr_data (hist_wdata),
      .rd_addr (hist_raddr),
      .rd_data (hist_q)
   );

   tfc_ram #(.WIDTH(CNT_W), .DEPTH(NCHAN)) u_count (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (ch_req),
      .rd_data (cnt_q)
   );

   tfc_ram #(.WIDTH(PS_W), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (cmd.cal_write),
      .wr_addr (mk_addr(ch_ff, b_ff)),
      .wr_data (quot_ff),
      .rd_addr (mk_addr(ch_req, bin_req)),
      .rd_data (calib_q)
   );

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      div_t    = {rem_ff, lo_ff[PS_W-1]};
      div_diff = div_t - {1'b0, total_ff};
      div_ge   = div_t >= {1'b0, total_ff};
      rem_in   = div_ge ? div_diff[TOT_W-1:0] : div_t[TOT_W-1:0];
   end

   assign res_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_stat_ff   <= '0;
         period_ff     <= PERIOD_RESET;
         clr_addr_ff   <= '0;
         calib_flag_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_MIN_STAT: min_stat_ff <= csr_wdata;
               CSR_PERIOD:   period_ff   <= csr_wdata[PS_W-1:0];
               default:      min_stat_ff <= min_stat_ff;
            endcase
         end
         if (cmd.clr_step) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (cmd.cal_write && st.bin_last) begin
            calib_flag_ff[ch_ff] <= 1'b1;
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         func_ff    <= func_type'(req_func);
         chan_ok_ff <= chan_ok_req;
         bin_ok_ff  <= bin_ok_req;
         ch_ff      <= ch_req;
         addr_ff    <= mk_addr(ch_req, bin_req);
      end
      if (cmd.exec) begin
         total_ff <= '0;
         // Only a successful read carries a table value.
         pend_calib_ff <= ((func_ff == FUNC_READ) && chan_ok_ff && bin_ok_ff &&
                           calib_flag_ff[ch_ff]) ? calib_q : '0;
         if (func_ff == FUNC_NONE) begin
            pend_status_ff <= ST_OK;
            pend_total_ff  <= '0;
         end else if (!chan_ok_ff) begin
            pend_status_ff <= ST_RANGE;
            pend_total_ff  <= '0;
         end else begin
            pend_total_ff <= (func_ff == FUNC_HIT) ? cnt_new : cnt_q;
            unique case (func_ff)
               FUNC_HIT: pend_status_ff <= ST_OK;
               FUNC_CAL: pend_status_ff <= ST_FEW;
               FUNC_READ: begin
                  if (!bin_ok_ff) begin
                     pend_status_ff <= ST_RANGE;
                  end else if (!calib_flag_ff[ch_ff]) begin
                     pend_status_ff <= ST_UNCAL;
                  end else begin
                     pend_status_ff <= ST_OK;
                  end
               end
               default: pend_status_ff <= ST_OK;
            endcase
         end
      end
      if (cmd.bin_clr) begin
         b_ff    <= '0;
         part_ff <= '0;
      end
      if (cmd.sum_acc) begin
         total_ff <= total_ff + TOT_W'(hist_q);
         b_ff     <= b_ff + 1'b1;
      end
      if (cmd.part_acc) begin
         part_ff <= part_ff + TOT_W'(hist_q);
         prod_ff <= '0;
         k_ff    <= '0;
      end
      if (cmd.mul_step) begin
         if (period_ff[k_ff]) begin
            prod_ff <= prod_ff + (PROD_W'(part_ff) << k_ff);
         end
         k_ff <= k_ff + 1'b1;
      end
      if (cmd.div_init) begin
         rem_ff <= prod_ff[PROD_W-1:PS_W];
         lo_ff  <= prod_ff[PS_W-1:0];
         k_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff  <= rem_in;
         lo_ff   <= {lo_ff[PS_W-2:0], 1'b0};
         quot_ff <= {quot_ff[PS_W-2:0], div_ge};
         k_ff    <= k_ff + 1'b1;
      end
      if (cmd.cal_write) begin
         b_ff <= b_ff + 1'b1;
         if (st.bin_last) begin
            pend_status_ff <= ST_OK;
         end
      end
      if (cmd.res_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_calib_ff  <= pend_calib_ff;
         rsp_total_ff  <= pend_total_ff;
      end
   end

   always_comb begin
      st.clr_last   = clr_addr_ff == A_W'(DEPTH - 1);
      st.cal_go     = (func_ff == FUNC_CAL) && chan_ok_ff && (cnt_q > min_stat_ff);
      st.bin_last   = b_ff == BIN_W'(FINE_BINS - 1);
      st.step_last  = k_ff == STEP_LAST;
      st.total_zero = total_ff == '0;
      st.res_free   = res_free;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_calib_ps  = rsp_calib_ff;
   assign rsp_hit_total = rsp_total_ff;

endmodule

[rtl/tfc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC fine time calibrator controller
// Sequences the clearing pass, item execution and the calibration walk.
// ----------------------------------------------------------------------------
module tfc_ctrl import tfc_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type st,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SUM_RD,
      S_SUM_ACC,
      S_SUM_CHK,
      S_CAL_RD,
      S_CAL_ACC,
      S_MUL,
      S_DIV_INIT,
      S_DIV,
      S_CAL_WR,
      S_PUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept_ok;

   always_comb begin
      accept_ok     = (state_ff == S_IDLE) || ((state_ff == S_PUT) && st.res_free);
      req_stall     = !accept_ok;
      cmd           = '0;
      cmd.load_item = accept_ok && req_valid;
      state_in      = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec    = 1'b1;
            cmd.bin_clr = 1'b1;
            state_in    = st.cal_go ? S_SUM_RD : S_PUT;
         end
         S_SUM_RD: begin
            cmd.rd_loop = 1'b1;
            state_in    = S_SUM_ACC;
         end
         S_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = st.bin_last ? S_SUM_CHK : S_SUM_RD;
         end
         S_SUM_CHK: begin
            cmd.bin_clr = 1'b1;
            state_in    = st.total_zero ? S_PUT : S_CAL_RD;
         end
         S_CAL_RD: begin
            cmd.rd_loop = 1'b1;
            state_in    = S_CAL_ACC;
         end
         S_CAL_ACC: begin
            cmd.part_acc = 1'b1;
            state_in     = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (st.step_last) state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.step_last) state_in = S_CAL_WR;
         end
         S_CAL_WR: begin
            cmd.cal_write = 1'b1;
            state_in      = st.bin_last ? S_PUT : S_CAL_RD;
         end
         S_PUT: begin
            if (st.res_free) begin
               cmd.res_load = 1'b1;
               state_in     = req_valid ? S_EXEC : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[tb/tdc_fine_time_calibrator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDC fine time calibrator core testbench
// Drives hit, calibrate, read and no-op items through the core under several
// register settings and idling patterns. Every result is checked field by
// field against fixed values or an in-bench histogram and cal table model.
// ----------------------------------------------------------------------------
module tdc_fine_time_calibrator_core_tb;
   import tfc_pkg::*;

   localparam int NP = 2;
   localparam int NS = 2;
   localparam int NA = 16;
   localparam int NBINS = 1024;
   localparam int NCH = NP * NS * NA;
   localparam int STALL_LIMIT = 300000;

   typedef struct {
      func_type    func;
      logic [1:0]  plane;
      logic [1:0]  section;
      logic [4:0]  anode;
      logic [9:0]  fine_bin;
   } item_type;

   typedef struct {
      status_type  status;
      logic [15:0] calib_ps;
      logic [31:0] hit_total;
   } result_type;

   typedef struct {
      item_type   it;
      bit         typed;
      result_type want;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_func;
   logic [1:0]  req_plane;
   logic [1:0]  req_section;
   logic [4:0]  req_anode;
   logic [9:0]  req_fine_bin;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_calib_ps;
   logic [31:0] rsp_hit_total;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_wdata;

   tdc_fine_time_calibrator_core dut (.*);

   // Model state of the channels.
   bit [31:0] bin_counts [NCH][NBINS];
   bit [31:0] chan_hits [NCH];
   bit [15:0] cal_table [NCH][NBINS];
   bit        chan_calibrated [NCH];
   bit [31:0] min_stat;
   bit [15:0] period;

   result_type pending_results [$];
   int      mismatches;
   int      results_seen;
   int      hits_done;
   int      cals_done;
   int      reads_done;
   int      tx_pct;
   int      rx_pct;
   bit      pressure_req;
   bit      pressure_done;
   int      hold_left;
   int      quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   function automatic result_type calibrate_predict(input item_type it);
      result_type o;
      int ch;
      longint unsigned total;
      longint unsigned part;
      o = '{ST_OK, 16'd0, 32'd0};
      if (it.func == FUNC_NONE) return o;
      if (it.plane < 1 || it.plane > NP || it.section < 1 || it.section > NS ||
          it.anode < 1 || it.anode > NA) begin
         o.status = ST_RANGE;
         return o;
      end
      ch = ((int'(it.plane) - 1) * NS + (int'(it.section) - 1)) * NA + (int'(it.anode) - 1);
      case (it.func)
         FUNC_HIT: begin
            if (chan_hits[ch] != '1) chan_hits[ch]++;
            if (bin_counts[ch][it.fine_bin] != '1) bin_counts[ch][it.fine_bin]++;
            hits_done++;
         end
         FUNC_CAL: begin
            total = 0;
            if (chan_hits[ch] <= min_stat) begin
               o.status = ST_FEW;
            end else begin
               for (int b = 0; b < NBINS; b++) total += bin_counts[ch][b];
               if (total == 0) begin
                  o.status = ST_FEW;
               end else begin
                  part = 0;
                  for (int b = 0; b < NBINS; b++) begin
                     part += bin_counts[ch][b];
                     cal_table[ch][b] = 16'((longint'(period) * part) / total);
                  end
                  chan_calibrated[ch] = 1'b1;
                  cals_done++;
               end
            end
         end
         default: begin
            if (!chan_calibrated[ch]) begin
               o.status = ST_UNCAL;
            end else begin
               o.calib_ps = cal_table[ch][it.fine_bin];
               reads_done++;
            end
         end
      endcase
      o.hit_total = chan_hits[ch];
      return o;
   endfunction

   task automatic send_item(input item_type it, input bit typed, input result_type want);
      result_type got;
      while ($urandom_range(99) < tx_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= it.func;
      req_plane    <= it.plane;
      req_section  <= it.section;
      req_anode    <= it.anode;
      req_fine_bin <= it.fine_bin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = calibrate_predict(it);
      pending_results.push_back(typed ? want : got);
   endtask

   task automatic write_csr(input logic idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_MIN_STAT) min_stat = data;
      else period = data[15:0];
   endtask

   // Lets the last item drain before registers change.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic item_type random_item();
      item_type it;
      int r;
      r = $urandom_range(99);
      if (r < 6) begin
         it.func     = func_type'($urandom_range(3));
         it.plane    = 2'($urandom);
         it.section  = 2'($urandom);
         it.anode    = 5'($urandom);
         it.fine_bin = 10'($urandom);
         // Keep stray calibrations of in-range channels rare, they are slow.
         if (it.func == FUNC_CAL && $urandom_range(3) != 0) it.func = FUNC_NONE;
         return it;
      end
      it.plane    = 2'($urandom_range(1, NP));
      it.section  = 2'($urandom_range(1, NS));
      it.anode    = ($urandom_range(9) < 7) ? 5'(($urandom_range(2) * 7) + 1)
                                            : 5'($urandom_range(1, NA));
      it.fine_bin = 10'($urandom);
      r = $urandom_range(99);
      it.func = (r < 2) ? FUNC_CAL : (r < 72) ? FUNC_HIT : FUNC_READ;
      return it;
   endfunction

   // Result side: random stalls, plus one long hold-off when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall     <= 1'b0;
         hold_left     <= 0;
         pressure_done <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (pressure_req && !pressure_done) begin
         rsp_stall     <= 1'b1;
         hold_left     <= 400;
         pressure_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_pct);
      end
   end

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result items", 1, 0);
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_status !== exp_r.status)
               report_mismatch("status", rsp_status, exp_r.status);
            if (rsp_calib_ps !== exp_r.calib_ps)
               report_mismatch("calib_ps", rsp_calib_ps, exp_r.calib_ps);
            if (rsp_hit_total !== exp_r.hit_total)
               report_mismatch("hit_total", rsp_hit_total, exp_r.hit_total);
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("** tdc_fine_time_calibrator_core: FAILED **");
         $finish;
      end
   end

   row_type directed [22];

   initial begin
      logic [31:0] seg_min [4];
      logic [15:0] seg_period [4];
      int seg_mode [4];
      quiet_cycles = 0;
      mismatches = 0;
      results_seen = 0;
      tx_pct = 0;
      rx_pct = 0;
      pressure_req = 1'b0;
      min_stat = 32'd0;
      period = PERIOD_RESET;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_HIT;
      req_plane <= 2'd0;
      req_section <= 2'd0;
      req_anode <= 5'd0;
      req_fine_bin <= 10'd0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MIN_STAT;
      csr_wdata <= 32'd0;

      directed = '{
         '{'{FUNC_READ, 2'd1, 2'd1, 5'd1,  10'd0},    1, '{ST_UNCAL, 16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd0, 2'd1, 5'd1,  10'd5},    1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd3, 2'd1, 5'd1,  10'd5},    1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_CAL,  2'd1, 2'd0, 5'd1,  10'd0},    1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_READ, 2'd1, 2'd3, 5'd1,  10'd0},    1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd1, 2'd1, 5'd0,  10'd0},    1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd2, 2'd2, 5'd17, 10'd0},    1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_READ, 2'd2, 2'd2, 5'd31, 10'd1023}, 1, '{ST_RANGE, 16'd0, 32'd0}},
         '{'{FUNC_NONE, 2'd3, 2'd3, 5'd31, 10'd1023}, 1, '{ST_OK,    16'd0, 32'd0}},
         '{'{FUNC_CAL,  2'd1, 2'd1, 5'd1,  10'd0},    1, '{ST_FEW,   16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd1, 2'd1, 5'd1,  10'd0},    1, '{ST_OK,    16'd0, 32'd1}},
         '{'{FUNC_HIT,  2'd2, 2'd2, 5'd16, 10'd1023}, 1, '{ST_OK,    16'd0, 32'd1}},
         '{'{FUNC_READ, 2'd2, 2'd2, 5'd16, 10'd1023}, 1, '{ST_UNCAL, 16'd0, 32'd1}},
         '{'{FUNC_CAL,  2'd1, 2'd1, 5'd1,  10'd0},    1, '{ST_OK,    16'd0, 32'd1}},
         '{'{FUNC_READ, 2'd1, 2'd1, 5'd1,  10'd0},    1, '{ST_OK,    16'd5000, 32'd1}},
         '{'{FUNC_READ, 2'd1, 2'd1, 5'd1,  10'd1023}, 1, '{ST_OK,    16'd5000, 32'd1}},
         '{'{FUNC_HIT,  2'd1, 2'd1, 5'd1,  10'd512},  0, '{ST_OK, 16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd1, 2'd1, 5'd1,  10'd1023}, 0, '{ST_OK, 16'd0, 32'd0}},
         '{'{FUNC_HIT,  2'd1, 2'd1, 5'd1,  10'd1},    0, '{ST_OK, 16'd0, 32'd0}},
         '{'{FUNC_CAL,  2'd1, 2'd1, 5'd1,  10'd0},    0, '{ST_OK, 16'd0, 32'd0}},
         '{'{FUNC_READ, 2'd1, 2'd1, 5'd1,  10'd511},  0, '{ST_OK, 16'd0, 32'd0}},
         '{'{FUNC_READ, 2'd1, 2'd1, 5'd1,  10'd1022}, 0, '{ST_OK, 16'd0, 32'd0}}
      };

      seg_min    = '{32'd3, 32'hFFFF_FFFF, 32'd0, 32'd7};
      seg_period = '{16'd65535, 16'd1, 16'd0, 16'd5000};
      seg_mode   = '{0, 1, 2, 0};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      write_csr(CSR_MIN_STAT, 32'd0);
      write_csr(CSR_PERIOD, 32'(PERIOD_RESET));
      foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].want);
      drain();

      for (int s = 0; s < 4; s++) begin
         write_csr(CSR_MIN_STAT, seg_min[s]);
         write_csr(CSR_PERIOD, 32'(seg_period[s]));
         tx_pct = (seg_mode[s] == 0) ? 37 : (seg_mode[s] == 1) ? 46 : 0;
         rx_pct = (seg_mode[s] == 0) ? 46 : (seg_mode[s] == 1) ? 37 : 0;
         // Hold the result side off for a long stretch so the core backs up.
         if (s == 2) pressure_req = 1'b1;
         for (int n = 0; n < 232; n++) send_item(random_item(), 1'b0, '{ST_OK, 16'd0, 32'd0});
         drain();
      end

      $display("covered %0d results: %0d hits, %0d good calibrations, %0d good reads,",
               results_seen, hits_done, cals_done, reads_done);
      $display("four register settings including the extremes, with and without idling");
      if (mismatches == 0) begin
         $display("** tdc_fine_time_calibrator_core: PASSED **");
      end else begin
         $display("** tdc_fine_time_calibrator_core: FAILED **");
      end
      $finish;
   end

endmodule

[tdc_fine_time_calibrator_core.f]
+incdir+rtl
rtl/tfc_pkg.sv
rtl/tfc_ram.sv
rtl/tfc_datapath.sv
rtl/tfc_ctrl.sv
rtl/tdc_fine_time_calibrator_core.sv
tb/tdc_fine_time_calibrator_core_tb.sv
